FILE: hdl/pbmd_pkg.sv
// Shared types and constants for the bilinear mesh deposit block.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package pbmd_pkg;

    // Fixed field widths of the request and response channels.
    localparam int POS_FIELD_BITS  = 16;
    localparam int NODE_INDEX_BITS = 11;
    localparam int NODE_VALUE_BITS = 48;

    // Width of one reciprocal digit that the weight divider multiplies per cycle.
    localparam int RECIP_DIGIT_BITS = 16;

    // Request codes.
    localparam logic REQ_DEPOSIT = 1'b0;
    localparam logic REQ_READ    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_START,
        ST_DIV
    } pbmd_state_t;

endpackage

`default_nettype wire

FILE: hdl/pbmd_req_if.sv
// Request channel: valid/ready handshake with a deposit or read request.
// Depends on pbmd_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pbmd_req_if;
    import pbmd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic [POS_FIELD_BITS-1:0]  pos_x;
    logic [POS_FIELD_BITS-1:0]  pos_y;
    logic [NODE_INDEX_BITS-1:0] node_index;

    modport source (output valid, req_type, pos_x, pos_y, node_index, input ready);
    modport sink   (input valid, req_type, pos_x, pos_y, node_index, output ready);
endinterface

`default_nettype wire

FILE: hdl/pbmd_rsp_if.sv
// Response channel: valid/ready handshake carrying one mesh node value.
// Depends on pbmd_pkg for the field width.
`timescale 1ns / 1ps
`default_nettype none

interface pbmd_rsp_if;
    import pbmd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [NODE_VALUE_BITS-1:0] node_value;

    modport source (output valid, node_value, input ready);
    modport sink   (input valid, node_value, output ready);
endinterface

`default_nettype wire

FILE: hdl/particle_bilinear_mesh_deposit.sv
// Cloud-in-cell deposit: a deposit walks the four corners in turn, each through
// ST_MUL, ST_START and ST_DIV, in which the weight divider walks DIGITS =
// ceil((2*POSITION_BITS + 2) / 16) reciprocal digits; the four corners share one
// divider and the memory's read and write ports. A read's result is registered in
// the memory read register and then in the output register, which loads once any
// earlier response has been taken. After reset the mesh is zeroed while requests are held off.
`timescale 1ns / 1ps
`default_nettype none

module particle_bilinear_mesh_deposit #(
    parameter int CELLS_X       = 32,
    parameter int CELLS_Y       = 32,
    parameter int POSITION_BITS = 16,
    parameter int ACCUM_BITS    = 48
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pbmd_req_if.sink   req,
    pbmd_rsp_if.source rsp
);
    import pbmd_pkg::*;

    localparam int P          = POSITION_BITS;
    localparam int ROW_NODES  = CELLS_X + 1;
    localparam int NODE_COUNT = (CELLS_X + 1) * (CELLS_Y + 1);
    localparam int AW         = $clog2(NODE_COUNT);
    localparam int XW         = $clog2(CELLS_X);
    localparam int YW         = $clog2(CELLS_Y);
    localparam int SXW        = P + XW;
    localparam int SYW        = P + YW;
    localparam int FW         = P + 1;
    localparam int QW         = 2 * P + 1;
    localparam int SW         = ((ACCUM_BITS > QW) ? ACCUM_BITS : QW) + 1;
    localparam int DIVISOR    = CELLS_X * CELLS_Y;

    pbmd_state_t state_reg;
    pbmd_state_t state_next;

    logic                  accept;
    logic                  clearing;
    logic                  mesh_rd_en;
    logic [AW-1:0]         mesh_rd_addr;
    logic [ACCUM_BITS-1:0] mesh_rd_data;
    logic                  mesh_wr_en;
    logic [ACCUM_BITS-1:0] mesh_wr_data;
    logic                  div_start;
    logic                  div_busy;
    logic [QW-1:0]         div_quot;
    logic                  out_load;

    logic [31:0]           px_wide;
    logic [31:0]           py_wide;
    logic [31:0]           idx_wide;
    logic [SXW-1:0]        sx;
    logic [SYW-1:0]        sy;

    logic [SXW-1:0]        sx_reg;
    logic [SYW-1:0]        sy_reg;
    logic [1:0]            corner_reg;
    logic [AW-1:0]         base_reg;
    logic [QW-1:0]         product_reg;
    logic                  in_range_reg;
    logic                  out_valid_reg;
    logic [NODE_VALUE_BITS-1:0] out_value_reg;

    logic [FW-1:0]         off_x;
    logic [FW-1:0]         off_y;
    logic [FW-1:0]         fac_x;
    logic [FW-1:0]         fac_y;
    logic [2*FW-1:0]       prod_full;
    logic [AW-1:0]         corner_addr;
    logic [SW-1:0]         acc_sum;
    logic [63:0]           node_wide;
    logic [NODE_VALUE_BITS-1:0] node_sat;

    pbmd_mesh #(
        .NODE_COUNT (NODE_COUNT),
        .ACCUM_BITS (ACCUM_BITS)
    ) u_mesh (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (mesh_rd_en),
        .rd_addr  (mesh_rd_addr),
        .rd_data  (mesh_rd_data),
        .wr_en    (mesh_wr_en),
        .wr_addr  (corner_addr),
        .wr_data  (mesh_wr_data),
        .clearing (clearing)
    );

    pbmd_div #(
        .NUM_BITS (QW),
        .DIVISOR  (DIVISOR)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (product_reg),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    // Position bits above POSITION_BITS are dropped. Since the position is
    // below one, the cell index never reaches CELLS_X, so no clamp is needed.
    assign px_wide  = 32'(req.pos_x);
    assign py_wide  = 32'(req.pos_y);
    assign idx_wide = 32'(req.node_index);
    assign sx       = SXW'(px_wide[P-1:0]) * SXW'(CELLS_X);
    assign sy       = SYW'(py_wide[P-1:0]) * SYW'(CELLS_Y);

    // Corner order: (i,j), (i+1,j), (i,j+1), (i+1,j+1).
    assign off_x     = {1'b0, sx_reg[P-1:0]};
    assign off_y     = {1'b0, sy_reg[P-1:0]};
    assign fac_x     = corner_reg[0] ? off_x : {1'b1, {P{1'b0}}} - off_x;
    assign fac_y     = corner_reg[1] ? off_y : {1'b1, {P{1'b0}}} - off_y;
    assign prod_full = fac_x * fac_y;

    assign corner_addr = base_reg + AW'(corner_reg[0])
                       + (corner_reg[1] ? AW'(ROW_NODES) : AW'(0));

    assign acc_sum      = SW'(mesh_rd_data) + SW'(div_quot);
    assign mesh_wr_data = (acc_sum > SW'({ACCUM_BITS{1'b1}})) ? {ACCUM_BITS{1'b1}}
                                                              : acc_sum[ACCUM_BITS-1:0];

    assign node_wide = in_range_reg ? 64'(mesh_rd_data) : 64'(0);
    assign node_sat  = (node_wide > 64'({NODE_VALUE_BITS{1'b1}})) ? {NODE_VALUE_BITS{1'b1}}
                                                                  : node_wide[NODE_VALUE_BITS-1:0];

    assign accept = req.valid && req.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req.req_type == REQ_READ) ? ST_READ : ST_MUL;
                end
            end
            ST_READ:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MUL:
            begin
                state_next = ST_START;
            end
            ST_START:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = (corner_reg == 2'd3) ? ST_IDLE : ST_MUL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready    = 1'b0;
        mesh_rd_en   = 1'b0;
        mesh_rd_addr = idx_wide[AW-1:0];
        mesh_wr_en   = 1'b0;
        div_start    = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req.ready  = !clearing;
                mesh_rd_en = req.valid && !clearing && (req.req_type == REQ_READ);
            end
            ST_READ:
            begin
                out_load = !out_valid_reg || rsp.ready;
            end
            ST_START:
            begin
                // The node read overlaps the division; the data register
                // holds until the sum is written back.
                mesh_rd_en   = 1'b1;
                mesh_rd_addr = corner_addr;
                div_start    = 1'b1;
            end
            ST_DIV:
            begin
                mesh_wr_en = !div_busy;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            corner_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                corner_reg <= '0;
            end
            else if (mesh_wr_en)
            begin
                corner_reg <= corner_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sx_reg       <= sx;
            sy_reg       <= sy;
            in_range_reg <= idx_wide < 32'(NODE_COUNT);
        end
        if (state_reg == ST_MUL)
        begin
            product_reg <= prod_full[QW-1:0];
            base_reg    <= AW'(sy_reg[SYW-1:P]) * AW'(ROW_NODES) + AW'(sx_reg[SXW-1:P]);
        end
        if (out_load)
        begin
            out_value_reg <= node_sat;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.node_value = out_value_reg;

endmodule

`default_nettype wire

FILE: hdl/pbmd_div.sv
// Divider by a fixed divisor: floor(num / DIVISOR) by multiplication with the
// rounded-up reciprocal, one reciprocal digit per cycle. Depends on pbmd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pbmd_div #(
    parameter int NUM_BITS = 33,
    parameter int DIVISOR  = 1024
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [NUM_BITS-1:0] num,
    output logic                     busy,
    output logic [NUM_BITS-1:0]      quot
);
    import pbmd_pkg::*;

    // The reciprocal carries NUM_BITS + clog2(DIVISOR) fraction bits, so the
    // truncated product equals the exact floor for every numerator.
    localparam int DW    = RECIP_DIGIT_BITS;
    localparam int L     = $clog2(DIVISOR);
    localparam int S     = NUM_BITS + L;
    localparam int MW    = NUM_BITS + 1;
    localparam int STEPS = (MW + DW - 1) / DW;
    localparam int PW    = STEPS * DW;
    localparam int TW    = NUM_BITS + DW;
    localparam int SH    = S - DW * (STEPS - 1);
    localparam int CW    = $clog2(STEPS + 1);

    localparam logic [S:0]    POW        = (S+1)'(1) << S;
    localparam logic [S:0]    RECIP_FULL = (POW + (S+1)'(DIVISOR - 1)) / (S+1)'(DIVISOR);
    localparam logic [PW-1:0] RECIP      = PW'(RECIP_FULL);

    logic                busy_reg;
    logic [CW-1:0]       count_reg;
    logic [NUM_BITS-1:0] num_reg;
    logic [PW-1:0]       recip_reg;
    logic [TW-1:0]       acc_reg;
    logic [TW-1:0]       acc_next;
    logic [TW-1:0]       quot_wide;

    // Each step drops the digit's low bits; later partial products start above
    // them, so no carry out of the dropped bits is ever lost.
    always_comb
    begin
        acc_next = (acc_reg >> DW) + TW'(num_reg) * TW'(recip_reg[DW-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            count_reg <= CW'(STEPS);
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg - 1'b1;
            if (count_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg   <= num;
            recip_reg <= RECIP;
            acc_reg   <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg   <= acc_next;
            recip_reg <= recip_reg >> DW;
        end
    end

    assign quot_wide = acc_reg >> SH;
    assign busy      = busy_reg;
    assign quot      = quot_wide[NUM_BITS-1:0];

endmodule

`default_nettype wire

FILE: hdl/pbmd_mesh.sv
// Accumulator mesh storage: one synchronous memory with a registered read
// port, one write port and a zeroing sweep after reset. Uses pbmd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pbmd_mesh #(
    parameter int NODE_COUNT = 1089,
    parameter int ACCUM_BITS = 48
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          rd_en,
    input  wire logic [$clog2(NODE_COUNT)-1:0] rd_addr,
    output logic [ACCUM_BITS-1:0]              rd_data,
    input  wire logic                          wr_en,
    input  wire logic [$clog2(NODE_COUNT)-1:0] wr_addr,
    input  wire logic [ACCUM_BITS-1:0]         wr_data,
    output logic                               clearing
);
    import pbmd_pkg::*;

    localparam int AW = $clog2(NODE_COUNT);

    logic [ACCUM_BITS-1:0] mem [NODE_COUNT];
    logic [ACCUM_BITS-1:0] rd_data_reg;
    logic                  clearing_reg;
    logic [AW-1:0]         clear_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg   <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
            if (clear_addr_reg == AW'(NODE_COUNT - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clear_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clearing_reg;

endmodule

`default_nettype wire
